FILE: design/lmts_pkg.sv
// Shared types, codes and timing constants of the display mode timer.
package lmts_pkg;

  // Word formats on the ports
  typedef struct packed {
    logic [1:0] func;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       stat_irq;
    logic       vblank_irq;
  } out_word_t;

  // Incoming function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Command kinds after classification
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] reg_index;
    logic [7:0] data;
  } cmd_t;

  // Register offsets from FF40
  localparam logic [3:0] REG_LCDC = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_SCY  = 4'd2;
  localparam logic [3:0] REG_SCX  = 4'd3;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;
  localparam logic [3:0] REG_BGP  = 4'd7;
  localparam logic [3:0] REG_OBP0 = 4'd8;
  localparam logic [3:0] REG_OBP1 = 4'd9;
  localparam logic [3:0] REG_WY   = 4'd10;
  localparam logic [3:0] REG_WX   = 4'd11;

  // STAT modes
  localparam logic [1:0] LM_HBLANK   = 2'd0;
  localparam logic [1:0] LM_VBLANK   = 2'd1;
  localparam logic [1:0] LM_OAM_SCAN = 2'd2;
  localparam logic [1:0] LM_DRAWING  = 2'd3;

  // Interrupt sources, in STAT bit order 3..6
  localparam logic [3:0] SRC_HBLANK = 4'b0001;
  localparam logic [3:0] SRC_VBLANK = 4'b0010;
  localparam logic [3:0] SRC_OAM    = 4'b0100;
  localparam logic [3:0] SRC_LYC    = 4'b1000;

  // Line timing
  localparam logic [8:0] OAM_END   = 9'd80;
  localparam logic [8:0] DRAW_END  = 9'd252;
  localparam logic [8:0] LINE_DOTS = 9'd456;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] ALL_LINES     = 8'd154;
  localparam logic [7:0] LY_TEST_VALUE = 8'h90;

  localparam int QUEUE_DEPTH = 4;

endpackage

FILE: design/lmts_front.sv
// Front end: accepts input words, classifies them and queues commands.
module lmts_front #(
  parameter int QUEUE_DEPTH = lmts_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lmts_pkg::in_word_t in_word,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lmts_pkg::cmd_t    cmd
);
  import lmts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;
  cmd_t          classified;

  always_comb begin
    classified.reg_index = in_word.reg_index;
    classified.data      = in_word.write_data;
    unique case (in_word.func)
      FUNC_TICK:  classified.kind = CMD_TICK;
      FUNC_WRITE: classified.kind = CMD_WRITE;
      FUNC_READ:  classified.kind = CMD_READ;
      default:    classified.kind = CMD_NOP;
    endcase
  end

  assign in_ready  = (count != CW'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/lmts_back.sv
// Back end: register file, dot and line timing, STAT logic, output register.
module lmts_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  lmts_pkg::cmd_t     cmd,
  input  logic               test_ly_override,
  output logic               out_valid,
  input  logic               out_ready,
  output lmts_pkg::out_word_t out_word
);
  import lmts_pkg::*;

  typedef struct packed {
    logic [6:0] stat;
    logic [3:0] act;
    logic       pulse;
  } upd_t;

  logic [7:0] lcd_control;
  logic [6:0] stat_bits;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] line_number;
  logic [7:0] line_compare;
  logic [7:0] bgp;
  logic [7:0] obp0;
  logic [7:0] obp1;
  logic [7:0] win_y;
  logic [7:0] win_x;
  logic [3:0] active_sources;
  logic [8:0] dot_counter;

  logic [7:0] lcd_control_next;
  logic [7:0] scroll_y_next;
  logic [7:0] scroll_x_next;
  logic [7:0] line_number_next;
  logic [7:0] line_compare_next;
  logic [7:0] bgp_next;
  logic [7:0] obp0_next;
  logic [7:0] obp1_next;
  logic [7:0] win_y_next;
  logic [7:0] win_x_next;
  logic [8:0] dot_counter_next;
  upd_t       u;
  logic       vblank_pulse;
  logic [7:0] rd;
  logic       exec;

  function automatic upd_t raise(upd_t a, logic [3:0] src);
    upd_t r;
    logic was_high;
    r        = a;
    was_high = |(a.act & a.stat[6:3]);
    r.act    = a.act | src;
    if (!was_high && (|(r.act & a.stat[6:3]))) begin
      r.pulse = 1'b1;
    end
    return r;
  endfunction

  function automatic upd_t compare(upd_t a, logic [7:0] ly, logic [7:0] lyc);
    upd_t r;
    r = a;
    if (ly == lyc) begin
      r.stat[2] = 1'b1;
      if (r.stat[6]) begin
        r = raise(r, SRC_LYC);
      end
    end else begin
      r.stat[2] = 1'b0;
      r.act     = r.act & ~SRC_LYC;
    end
    return r;
  endfunction

  assign exec      = cmd_valid && (!out_valid || out_ready);
  assign cmd_ready = exec;

  always_comb begin
    lcd_control_next  = lcd_control;
    scroll_y_next     = scroll_y;
    scroll_x_next     = scroll_x;
    line_number_next  = line_number;
    line_compare_next = line_compare;
    bgp_next          = bgp;
    obp0_next         = obp0;
    obp1_next         = obp1;
    win_y_next        = win_y;
    win_x_next        = win_x;
    dot_counter_next  = dot_counter;
    u.stat            = stat_bits;
    u.act             = active_sources;
    u.pulse           = 1'b0;
    vblank_pulse      = 1'b0;
    rd                = '0;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (lcd_control[7]) begin
          dot_counter_next = dot_counter + 9'd1;
          unique case (stat_bits[1:0])
            LM_OAM_SCAN: begin
              if (dot_counter_next >= OAM_END) begin
                u.stat[1:0] = LM_DRAWING;
                u.act       = u.act & ~SRC_OAM;
              end
            end
            LM_DRAWING: begin
              if (dot_counter_next >= DRAW_END) begin
                u.stat[1:0] = LM_HBLANK;
                u = raise(u, SRC_HBLANK);
              end
            end
            LM_HBLANK: begin
              if (dot_counter_next >= LINE_DOTS) begin
                dot_counter_next = '0;
                line_number_next = line_number + 8'd1;
                u = compare(u, line_number_next, line_compare);
                if (line_number_next >= VISIBLE_LINES) begin
                  u.stat[1:0]  = LM_VBLANK;
                  u            = raise(u, SRC_VBLANK);
                  vblank_pulse = 1'b1;
                end else begin
                  u.stat[1:0] = LM_OAM_SCAN;
                  u           = raise(u, SRC_OAM);
                end
                u.act = u.act & ~SRC_HBLANK;
              end
            end
            default: begin
              if (dot_counter_next >= LINE_DOTS) begin
                dot_counter_next = '0;
                line_number_next = line_number + 8'd1;
                if (line_number_next >= ALL_LINES) begin
                  line_number_next = '0;
                  u.stat[1:0] = LM_OAM_SCAN;
                  u           = raise(u, SRC_OAM);
                  u.act       = u.act & ~SRC_VBLANK;
                end
                u = compare(u, line_number_next, line_compare);
              end
            end
          endcase
        end
      end
      CMD_WRITE: begin
        unique case (cmd.reg_index)
          REG_LCDC: lcd_control_next = cmd.data;
          REG_STAT: begin
            if ((|(active_sources & cmd.data[6:3])) &&
                !(|(active_sources & stat_bits[6:3]))) begin
              u.pulse = 1'b1;
            end
            u.stat = {cmd.data[6:3], stat_bits[2:0]};
            u = compare(u, line_number, line_compare);
          end
          REG_SCY:  scroll_y_next = cmd.data;
          REG_SCX:  scroll_x_next = cmd.data;
          REG_LY: begin
            line_number_next = cmd.data;
            u = compare(u, cmd.data, line_compare);
          end
          REG_LYC: begin
            line_compare_next = cmd.data;
            u = compare(u, line_number, cmd.data);
          end
          REG_BGP:  bgp_next   = cmd.data;
          REG_OBP0: obp0_next  = cmd.data;
          REG_OBP1: obp1_next  = cmd.data;
          REG_WY:   win_y_next = cmd.data;
          REG_WX:   win_x_next = cmd.data;
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (cmd.reg_index)
          REG_LCDC: rd = lcd_control;
          REG_STAT: rd = {1'b0, stat_bits};
          REG_SCY:  rd = scroll_y;
          REG_SCX:  rd = scroll_x;
          REG_LY:   rd = test_ly_override ? LY_TEST_VALUE : line_number;
          REG_LYC:  rd = line_compare;
          REG_BGP:  rd = bgp;
          REG_OBP0: rd = obp0;
          REG_OBP1: rd = obp1;
          REG_WY:   rd = win_y;
          REG_WX:   rd = win_x;
          default:  rd = '0;
        endcase
      end
      default: ;
    endcase
  end

  // Architectural state and result word advance only on an executed command
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control    <= '0;
      stat_bits      <= '0;
      scroll_y       <= '0;
      scroll_x       <= '0;
      line_number    <= '0;
      line_compare   <= '0;
      bgp            <= '0;
      obp0           <= '0;
      obp1           <= '0;
      win_y          <= '0;
      win_x          <= '0;
      active_sources <= '0;
      dot_counter    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (exec) begin
        lcd_control    <= lcd_control_next;
        stat_bits      <= u.stat;
        scroll_y       <= scroll_y_next;
        scroll_x       <= scroll_x_next;
        line_number    <= line_number_next;
        line_compare   <= line_compare_next;
        bgp            <= bgp_next;
        obp0           <= obp0_next;
        obp1           <= obp1_next;
        win_y          <= win_y_next;
        win_x          <= win_x_next;
        active_sources <= u.act;
        dot_counter    <= dot_counter_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_word.read_data  <= rd;
      out_word.stat_irq   <= u.pulse;
      out_word.vblank_irq <= vblank_pulse;
    end
  end

endmodule

FILE: design/lcd_mode_timer_stat_irq.sv
// Top level of the display mode timer with STAT and vblank interrupt logic.
//
//   channel  | direction | word                               | handshake
//   ---------+-----------+------------------------------------+----------------
//   in       | input     | func, reg_index, write_data        | in_valid/ready
//   out      | output    | read_data, stat_irq, vblank_irq    | out_valid/ready
//   cfg      | input     | test_ly_override (one bit)         | cfg_valid/ready
//
// Throughput is one word per cycle while the output is not stalled. An accepted word is
// written into a queue slot, then executed from the queue head into the output register,
// from which it leaves. The back end updates the timing and STAT state once per executed
// command, which sets the rate. rst is synchronous and clears the state registers, the queue
// pointers, the queue count and out_valid. An output stall fills the queue, then drops
// in_ready; the cfg port is always ready, so write it only while the block is idle.
module lcd_mode_timer_stat_irq #(
  parameter int QUEUE_DEPTH = lmts_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output lmts_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import lmts_pkg::*;

  logic test_ly_override;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Test override for LY reads; the user writes it only while the block is idle, unenforced here
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_ly_override <= 1'b0;
    end else if (cfg_valid) begin
      test_ly_override <= cfg_data;
    end
  end

  // Classify and queue incoming words
  lmts_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Execute commands against the register and timing state
  lmts_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .test_ly_override (test_ly_override),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word)
  );

endmodule
